// ===== sv/audio_loop_recorder_overdub_top_macros.svh =====
// Assertion macros shared by the loop recorder RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef AUDIO_LOOP_RECORDER_OVERDUB_TOP_MACROS_SVH
`define AUDIO_LOOP_RECORDER_OVERDUB_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ALR_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ALR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ALR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/alr_pkg.sv =====
// Shared types and codes for the loop recorder.
// No dependencies.
package alr_pkg;

  // Operation codes of an input transaction
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ON        = 3'd1;
  localparam logic [2:0] OP_OFF       = 3'd2;
  localparam logic [2:0] OP_REC_START = 3'd3;
  localparam logic [2:0] OP_REC_STOP  = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // Transport modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_REC  = 2'd2;

  // Work handed from the control stage to the read-modify-write stage
  typedef struct packed {
    logic        play_act;   // a stored sample is played
    logic        rec_wr;     // the memory entry at the write position is written
    logic        overdub;    // the write adds to the stored sample
    logic [15:0] sample_in;
    logic [1:0]  mode;
    logic [15:0] play_pos;
    logic [16:0] rec_pos;
    logic [16:0] loop_len;
  } alr_stage_t;

endpackage

// ===== sv/alr_mem.sv =====
// Loop sample memory: one write port, two registered read ports.
// Depends on nothing but its parameters.
module alr_mem #(
  parameter int DEPTH       = 65536,
  parameter int SAMPLE_BITS = 16,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   ra_en,
  input  logic [AW-1:0]          ra_addr,
  output logic [SAMPLE_BITS-1:0] ra_data,
  input  logic                   rb_en,
  input  logic [AW-1:0]          rb_addr,
  output logic [SAMPLE_BITS-1:0] rb_data
);

  logic [SAMPLE_BITS-1:0] loop_mem [DEPTH];
  logic [SAMPLE_BITS-1:0] ra_data_r;
  logic [SAMPLE_BITS-1:0] rb_data_r;

  // Write the modified sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      loop_mem[wr_addr] <= wr_data;
    end
  end

  // Read the play and record entries; data holds until the next read
  always_ff @(posedge clk) begin
    if (ra_en) begin
      ra_data_r <= loop_mem[ra_addr];
    end
    if (rb_en) begin
      rb_data_r <= loop_mem[rb_addr];
    end
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

// ===== sv/alr_ctrl.sv =====
// Transport control: mode, positions and loop length, updated per transaction.
// Depends on alr_pkg and the assertion macros header.
`include "audio_loop_recorder_overdub_top_macros.svh"
module alr_ctrl
  import alr_pkg::*;
#(
  parameter int DEPTH = 65536,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [2:0]  op,
  input  logic [15:0] sample_in,
  output alr_stage_t  stage,
  output logic        play_rd,
  output logic        rec_rd,
  output logic [AW-1:0] play_addr,
  output logic [AW-1:0] rec_addr
);

  localparam int PW                = AW + 1;
  localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] le_r, le_nxt;
  logic [PW-1:0] rp_inc, wp_inc;
  logic          has_loop, play_act, rec_act;

  // Decode the operation against the current state
  always_comb begin
    mode_nxt = mode_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    le_nxt   = le_r;
    play_act = 1'b0;
    rec_act  = 1'b0;
    has_loop = (le_r != '0);
    rp_inc   = {1'b0, rp_r} + PW'(1);
    wp_inc   = wp_r + PW'(1);
    case (op)
      OP_TICK: begin
        // advance the read position, wrap at the loop end
        if (has_loop && mode_r != MODE_STOP) begin
          play_act = 1'b1;
          rp_nxt   = (rp_inc >= le_r) ? '0 : rp_inc[AW-1:0];
        end
        // advance the write position; a first take closes the loop when full
        if (mode_r == MODE_REC) begin
          rec_act = 1'b1;
          if (has_loop) begin
            wp_nxt = (wp_inc >= le_r) ? '0 : wp_inc;
          end else begin
            wp_nxt = wp_inc;
            if (wp_inc >= DEPTH_W) begin
              le_nxt   = wp_inc;
              mode_nxt = MODE_STOP;
            end
          end
        end
      end
      OP_ON: begin
        if (has_loop && mode_r != MODE_REC) begin
          mode_nxt = MODE_PLAY;
        end
      end
      OP_OFF: begin
        if (mode_r == MODE_PLAY) begin
          mode_nxt = MODE_STOP;
          rp_nxt   = '0;
          wp_nxt   = '0;
        end
      end
      OP_REC_START: begin
        if (mode_r == MODE_PLAY) begin
          wp_nxt = {1'b0, rp_r};
        end else begin
          le_nxt = '0;
          wp_nxt = '0;
        end
        mode_nxt = MODE_REC;
      end
      OP_REC_STOP: begin
        if (!has_loop) begin
          le_nxt = wp_r;
        end
        mode_nxt = MODE_PLAY;
      end
      OP_CLEAR: begin
        le_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Hand the work and the reported state to the next stage
  always_comb begin
    stage.play_act  = play_act;
    stage.rec_wr    = rec_act && (wp_r < DEPTH_W);
    stage.overdub   = has_loop;
    stage.sample_in = sample_in;
    stage.mode      = mode_nxt;
    stage.play_pos  = 16'(rp_nxt);
    stage.rec_pos   = 17'(wp_nxt);
    stage.loop_len  = 17'(le_nxt);
  end

  assign play_addr = rp_r;
  assign rec_addr  = wp_r[AW-1:0];
  assign play_rd   = acc && play_act;
  assign rec_rd    = acc && stage.rec_wr && has_loop;

  // Update the transport state once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOP;
      rp_r   <= '0;
      wp_r   <= '0;
      le_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      le_r   <= le_nxt;
    end
  end

  `ALR_ASSERT_HOLDS(a_wp_range, wp_r <= DEPTH_W, "write position beyond memory depth")
  `ALR_ASSERT_HOLDS(a_le_range, le_r <= DEPTH_W, "loop length beyond memory depth")
  `ALR_ASSERT_IMPL(a_first_take_room, (mode_r == MODE_REC) && (le_r == '0), wp_r < DEPTH_W, "first take recording past a full memory")

endmodule

// ===== sv/alr_rmw.sv =====
// Read-modify-write stage: forwarding, saturating overdub, memory write, result register.
// Depends on alr_pkg and the assertion macros header.
`include "audio_loop_recorder_overdub_top_macros.svh"
module alr_rmw
  import alr_pkg::*;
#(
  parameter int DEPTH       = 65536,
  parameter int SAMPLE_BITS = 16,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  output logic                   in_ready,
  input  alr_stage_t             stage,
  input  logic [AW-1:0]          play_addr,
  input  logic [AW-1:0]          rec_addr,
  input  logic [SAMPLE_BITS-1:0] ra_data,
  input  logic [SAMPLE_BITS-1:0] rb_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [SAMPLE_BITS-1:0] wr_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_sample_out,
  output logic [1:0]             out_mode,
  output logic                   out_sounding,
  output logic [15:0]            out_play_position,
  output logic [16:0]            out_record_position,
  output logic [16:0]            out_loop_length
);

  localparam int SB = SAMPLE_BITS;
  localparam int EW = ((SB > 16) ? SB : 16) + 1;
  localparam logic [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

  logic          s1_v_r;
  alr_stage_t    s1_r;
  logic [AW-1:0] s1_addr_r;
  logic          fwd_play_r, fwd_rec_r;
  logic [SB-1:0] fwd_data_r;
  logic          s1_adv;

  logic [SB-1:0]        play_word, rec_word;
  logic signed [EW-1:0] samp_ext, base_ext, sum, played_ext;
  logic                 sat_ok;
  logic [15:0]          sample_out;

  logic        out_valid_r;
  logic [15:0] out_sample_r, out_play_r;
  logic [1:0]  out_mode_r;
  logic [16:0] out_rec_r, out_len_r;

  // Advance the stage when the result register is free or being drained
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  // Take the sample written in the cycle of the read over stale memory data
  assign play_word = fwd_play_r ? fwd_data_r : ra_data;
  assign rec_word  = fwd_rec_r ? fwd_data_r : rb_data;

  // Add the take to the stored sample and saturate to the sample width
  always_comb begin
    samp_ext   = EW'(signed'(s1_r.sample_in));
    base_ext   = s1_r.overdub ? EW'(signed'(rec_word)) : '0;
    sum        = samp_ext + base_ext;
    sat_ok     = (&sum[EW-1:SB-1]) || !(|sum[EW-1:SB-1]);
    wr_data    = sat_ok ? sum[SB-1:0] : (sum[EW-1] ? SAT_MIN : SAT_MAX);
    played_ext = EW'(signed'(play_word));
    sample_out = s1_r.play_act ? played_ext[15:0] : '0;
  end

  assign wr_en   = s1_adv && s1_r.rec_wr;
  assign wr_addr = s1_addr_r;

  // Track stage and result occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the transaction and note a write that lands with its reads
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r       <= stage;
      s1_addr_r  <= rec_addr;
      fwd_play_r <= wr_en && (wr_addr == play_addr);
      fwd_rec_r  <= wr_en && (wr_addr == rec_addr);
      fwd_data_r <= wr_data;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= sample_out;
      out_mode_r   <= s1_r.mode;
      out_play_r   <= s1_r.play_pos;
      out_rec_r    <= s1_r.rec_pos;
      out_len_r    <= s1_r.loop_len;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_out      = out_sample_r;
  assign out_mode            = out_mode_r;
  assign out_sounding        = (out_mode_r == MODE_PLAY);
  assign out_play_position   = out_play_r;
  assign out_record_position = out_rec_r;
  assign out_loop_length     = out_len_r;

  `ALR_ASSERT_IMPL(a_fwd_play, $past(rst_n) && $past(acc) && $past(wr_en) && ($past(wr_addr) == $past(play_addr)), fwd_play_r, "play read missed a same-cycle write")
  `ALR_ASSERT_NEXT(a_stall_hold, s1_v_r && !s1_adv, s1_v_r && $stable(ra_data) && $stable(rb_data), "read data lost while stalled")
  `ALR_ASSERT_NEXT(a_result_lands, s1_adv, out_valid_r, "advanced transaction did not reach the result register")

endmodule

// ===== sv/audio_loop_recorder_overdub_top.sv =====
// Loop recorder top level: control stage, sample memory and read-modify-write stage.
// Depends on alr_pkg, alr_ctrl, alr_mem and alr_rmw.
// Result path: an accepted transaction is captured in the stage register, then loaded
// into the output register when that register is free or being drained.
// Throughput: one transaction per cycle unless out_ready stalls; the play and overdub
// reads use both read ports, the single write port takes the stage's modified sample.
// Reset (rst_n low, synchronous): mode stopped, positions and loop length zero;
// sample memory contents are kept and are undefined until recorded.
module audio_loop_recorder_overdub_top
  import alr_pkg::*;
#(
  parameter int DEPTH       = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_sample_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample_out,
  output logic [1:0]  out_mode,
  output logic        out_sounding,
  output logic [15:0] out_play_position,
  output logic [16:0] out_record_position,
  output logic [16:0] out_loop_length
);

  localparam int AW = $clog2(DEPTH);

  logic                   acc;
  alr_stage_t             stage;
  logic                   play_rd, rec_rd;
  logic [AW-1:0]          play_addr, rec_addr;
  logic [SAMPLE_BITS-1:0] ra_data, rb_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;

  assign acc = in_valid && in_ready;

  alr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .op        (in_op),
    .sample_in (in_sample_in),
    .stage     (stage),
    .play_rd   (play_rd),
    .rec_rd    (rec_rd),
    .play_addr (play_addr),
    .rec_addr  (rec_addr)
  );

  alr_mem #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ra_en   (play_rd),
    .ra_addr (play_addr),
    .ra_data (ra_data),
    .rb_en   (rec_rd),
    .rb_addr (rec_addr),
    .rb_data (rb_data)
  );

  alr_rmw #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rmw (
    .clk                 (clk),
    .rst_n               (rst_n),
    .acc                 (acc),
    .in_ready            (in_ready),
    .stage               (stage),
    .play_addr           (play_addr),
    .rec_addr            (rec_addr),
    .ra_data             (ra_data),
    .rb_data             (rb_data),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sample_out      (out_sample_out),
    .out_mode            (out_mode),
    .out_sounding        (out_sounding),
    .out_play_position   (out_play_position),
    .out_record_position (out_record_position),
    .out_loop_length     (out_loop_length)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for audio_loop_recorder_overdub_top: a queue-fed driver,
// a checking monitor with a built-in loop recorder predictor, and a stall watchdog.
// Depends on alr_pkg and the audio_loop_recorder_overdub_top RTL.
module tb_top
  import alr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS    = 65536;
  localparam int CALM_ITEMS   = 80;     // last stretch of the run has no idling
  localparam int RANDOM_ITEMS = 470;
  localparam int FIRST_TAKE   = 40;
  localparam int HOLD_AT      = 200;    // result count that triggers the long back-pressure
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam logic signed [17:0] SAT_HI = 18'sd32767;
  localparam logic signed [17:0] SAT_LO = -18'sd32768;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] smp;
  } loop_cmd_t;

  typedef struct packed {
    logic [15:0] smp;
    logic [1:0]  mode;
    logic        snd;
    logic [15:0] ppos;
    logic [16:0] rpos;
    logic [16:0] llen;
  } loop_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = OP_TICK;
  logic [15:0] in_sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_sample_out;
  logic [1:0]  out_mode;
  logic        out_sounding;
  logic [15:0] out_play_position;
  logic [16:0] out_record_position;
  logic [16:0] out_loop_length;

  loop_cmd_t    cmd_queue[$];
  loop_status_t expected_status[$];
  int           errors = 0;
  int           n_results = 0;
  int           n_random = 0;
  bit           random_phase = 0;

  // Predictor state
  logic [1:0]         st_mode = MODE_STOP;
  logic [16:0]        st_rd = '0;
  logic [16:0]        st_wr = '0;
  logic [16:0]        st_end = '0;
  logic signed [15:0] st_mem [0:MEM_WORDS-1];

  audio_loop_recorder_overdub_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sample_out      (out_sample_out),
    .out_mode            (out_mode),
    .out_sounding        (out_sounding),
    .out_play_position   (out_play_position),
    .out_record_position (out_record_position),
    .out_loop_length     (out_loop_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the predicted looper and return its status
  function automatic loop_status_t advance_looper(logic [2:0] op, logic signed [15:0] smp);
    loop_status_t       r;
    logic signed [15:0] played;
    logic signed [17:0] sum;
    played = '0;
    case (op)
      OP_TICK: begin
        // play first, then record
        if (st_end != 0 && st_mode != MODE_STOP) begin
          played = st_mem[st_rd[15:0]];
          st_rd = st_rd + 17'd1;
          if (st_rd >= st_end) st_rd = '0;
        end
        if (st_mode == MODE_REC) begin
          if (st_wr < MEM_WORDS) begin
            if (st_end != 0) begin
              sum = smp + st_mem[st_wr[15:0]];
              if (sum > SAT_HI) st_mem[st_wr[15:0]] = 16'sh7FFF;
              else if (sum < SAT_LO) st_mem[st_wr[15:0]] = 16'sh8000;
              else st_mem[st_wr[15:0]] = sum[15:0];
            end else begin
              st_mem[st_wr[15:0]] = smp;
            end
          end
          st_wr = st_wr + 17'd1;
          if (st_end != 0) begin
            if (st_wr >= st_end) st_wr = '0;
          end else if (st_wr >= MEM_WORDS) begin
            // first take filled the memory
            st_end = st_wr;
            st_mode = MODE_STOP;
          end
        end
      end
      OP_ON: begin
        if (st_end != 0 && st_mode != MODE_REC) st_mode = MODE_PLAY;
      end
      OP_OFF: begin
        if (st_mode == MODE_PLAY) begin
          st_mode = MODE_STOP;
          st_rd = '0;
          st_wr = '0;
        end
      end
      OP_REC_START: begin
        if (st_mode == MODE_PLAY) begin
          st_wr = st_rd;
        end else begin
          st_end = '0;
          st_wr = '0;
        end
        st_mode = MODE_REC;
      end
      OP_REC_STOP: begin
        if (st_end == 0) st_end = st_wr;
        st_mode = MODE_PLAY;
      end
      OP_CLEAR: st_end = '0;
      default: ;
    endcase
    r.smp  = played;
    r.mode = st_mode;
    r.snd  = (st_mode == MODE_PLAY);
    r.ppos = st_rd[15:0];
    r.rpos = st_wr;
    r.llen = st_end;
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic [15:0] smp);
    loop_cmd_t c;
    c.op = op;
    c.smp = smp;
    cmd_queue.push_back(c);
    if (random_phase && op <= OP_CLEAR) n_random++;
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) queue_cmd(OP_TICK, pick_sample());
  endtask

  task automatic check_field(string fname, logic [16:0] exp_v, logic [16:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, fname, exp_v, act_v);
    end
  endtask

  // Driver: offer queued transactions, hold them until accepted, idle in bursts
  int        drv_gap = 0;
  loop_cmd_t drv_cmd;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(advance_looper(in_op, in_sample_in));
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_queue.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
          drv_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          drv_cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_op <= drv_cmd.op;
          in_sample_in <= drv_cmd.smp;
        end
      end
    end
  end

  // Monitor: check each result transaction, stall the output in bursts and once for long
  int           rcv_gap = 0;
  int           hold_cnt = 0;
  bit           hold_done = 0;
  loop_status_t mon_exp;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %0h", $time, out_sample_out);
        end else begin
          mon_exp = expected_status.pop_front();
          check_field("sample_out", 17'(mon_exp.smp), 17'(out_sample_out));
          check_field("mode", 17'(mon_exp.mode), 17'(out_mode));
          check_field("sounding", 17'(mon_exp.snd), 17'(out_sounding));
          check_field("play_position", 17'(mon_exp.ppos), 17'(out_play_position));
          check_field("record_position", mon_exp.rpos, out_record_position);
          check_field("loop_length", mon_exp.llen, out_loop_length);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1;
        hold_cnt = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else if (cmd_queue.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        rcv_gap = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // Control transactions from reset, with no loop present
    queue_cmd(OP_ON, 16'h0000);
    queue_cmd(OP_OFF, 16'h0000);
    queue_cmd(OP_REC_STOP, 16'h0000);
    queue_cmd(OP_TICK, 16'h1234);
    queue_cmd(OP_OFF, 16'h0000);
    queue_cmd(OP_CLEAR, 16'h0000);
    queue_cmd(3'd7, 16'hFFFF);
    // Short first take from entry zero, closed into a loop
    queue_cmd(OP_REC_START, 16'h0000);
    queue_ticks(FIRST_TAKE);
    queue_cmd(OP_REC_STOP, 16'h0000);
    // Play ten samples, then clear and record a fresh three-sample loop from entry zero
    queue_cmd(OP_ON, 16'h0000);
    queue_ticks(10);
    queue_cmd(OP_CLEAR, 16'h0000);
    queue_cmd(OP_REC_START, 16'h0000);
    queue_cmd(OP_REC_START, 16'h0000);
    queue_cmd(OP_TICK, 16'h7FFF);
    queue_cmd(OP_TICK, 16'h8000);
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_REC_STOP, 16'h0000);
    queue_cmd(OP_TICK, 16'h0000);
    // Overdub the loop, starting at the read position
    queue_cmd(OP_REC_START, 16'h0000);
    queue_cmd(OP_TICK, 16'h7FFF);
    queue_cmd(OP_TICK, 16'h8000);
    queue_cmd(OP_TICK, 16'hFFFF);
    queue_cmd(OP_REC_STOP, 16'h0000);
    queue_cmd(3'd6, 16'h5555);
    queue_cmd(3'd7, 16'hAAAA);
    queue_cmd(OP_OFF, 16'h0000);
    queue_cmd(OP_TICK, 16'h4321);

    // Random part: mostly well-formed takes and overdubs, some noise
    random_phase = 1;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fresh short take, then play it
          queue_cmd(OP_REC_START, pick_sample());
          queue_cmd(OP_REC_START, pick_sample());
          queue_ticks($urandom_range(1, 24));
          queue_cmd(OP_REC_STOP, pick_sample());
          queue_ticks($urandom_range(0, 30));
        end
        3, 4: begin
          // overdub the current loop
          queue_cmd(OP_ON, pick_sample());
          queue_cmd(OP_REC_START, pick_sample());
          queue_ticks($urandom_range(1, 30));
          queue_cmd(OP_REC_STOP, pick_sample());
          queue_ticks($urandom_range(0, 10));
        end
        5: begin
          // stop and restart playback
          queue_cmd(OP_OFF, pick_sample());
          queue_ticks($urandom_range(0, 4));
          queue_cmd(OP_ON, pick_sample());
          queue_ticks($urandom_range(0, 8));
        end
        6: begin
          // drop the loop while playing or recording
          queue_cmd(OP_CLEAR, pick_sample());
          queue_ticks($urandom_range(0, 6));
          queue_cmd(3'($urandom_range(OP_ON, OP_REC_STOP)), pick_sample());
          queue_ticks($urandom_range(0, 6));
        end
        default: begin
          // noise over every op code
          repeat ($urandom_range(1, 6)) queue_cmd(3'($urandom_range(0, 7)), pick_sample());
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all sent, all results back, then a quiet wait before the check
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
